FILE: rtl/tspd_pkg.sv
`default_nettype none

package tspd_pkg;

    // Request kinds carried by one input item.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_POLL  = 2'd1;
    localparam logic [1:0] REQ_REPLY = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // Send codes of a result item.
    localparam logic [1:0] SEND_NONE   = 2'd0;
    localparam logic [1:0] SEND_START  = 2'd1;
    localparam logic [1:0] SEND_READ   = 2'd2;
    localparam logic [1:0] SEND_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DEVICE_ADDRESS = 3'd0;
    localparam logic [2:0] CFG_MAX_MISSES     = 3'd1;
    localparam logic [2:0] CFG_CONVERT_TICKS  = 3'd2;
    localparam logic [2:0] CFG_RESEND_TICKS   = 3'd3;
    localparam logic [2:0] CFG_POWER_DIVISOR  = 3'd4;
    localparam logic [2:0] CFG_WRITE_FC       = 3'd5;
    localparam logic [2:0] CFG_READ_FC        = 3'd6;

    localparam logic [7:0]  MAX_VALID_ADDRESS = 8'd247;
    localparam logic [7:0]  MISS_SATURATE     = 8'hFF;
    localparam logic [9:0]  MILLI_SCALE       = 10'd1000;
    localparam logic [13:0] MEGA_ODD_PART     = 14'd15625;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        bus_accepts;
        logic [7:0]  source_address;
        logic [7:0]  function_code;
        logic [7:0]  byte_count;
        logic [15:0] result_word0;
        logic [15:0] result_word1;
        logic [15:0] result_word2;
        logic [15:0] result_word3;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         send_request;
        logic               link_lost;
        logic signed [31:0] speed_milli;
        logic signed [31:0] torque_milli;
        logic [31:0]        power_milli;
    } t_out_item;

    // One classified item handed from the front part to the back part.
    typedef struct packed {
        logic        decode;
        logic [1:0]  send_request;
        logic        link_lost;
        logic [31:0] speed_bits;
        logic [31:0] torque_bits;
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/tspd_front.sv
`default_nettype none

module tspd_front #(
    parameter int RESULT_REG_COUNT = 5
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [2:0]             i_cfg_index,
    input  wire [31:0]            i_cfg_data,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire tspd_pkg::t_in_item i_item,
    output logic                  o_job_valid,
    input  wire                   i_job_ready,
    output tspd_pkg::t_job        o_job,
    output logic [31:0]           o_power_divisor
);

    localparam logic [7:0] REPLY_BYTES = 8'(2 * RESULT_REG_COUNT);

    logic [7:0]  r_dev, r_max, r_wfc, r_rfc;
    logic [15:0] r_conv, r_resend, r_cd, n_cd;
    logic [31:0] r_div;
    logic        r_mode, n_mode;
    logic [7:0]  r_miss, n_miss;
    tspd_pkg::t_job n_job;
    logic        en, match, take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev    <= 8'd0;
            r_max    <= 8'd3;
            r_conv   <= 16'd100;
            r_resend <= 16'd200;
            r_div    <= 32'd9549;
            r_wfc    <= 8'd6;
            r_rfc    <= 8'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tspd_pkg::CFG_DEVICE_ADDRESS: r_dev <= i_cfg_data[7:0];
                tspd_pkg::CFG_MAX_MISSES:     r_max <= i_cfg_data[7:0];
                tspd_pkg::CFG_CONVERT_TICKS:  r_conv <= i_cfg_data[15:0];
                tspd_pkg::CFG_RESEND_TICKS:   r_resend <= i_cfg_data[15:0];
                tspd_pkg::CFG_POWER_DIVISOR:  r_div <= i_cfg_data;
                tspd_pkg::CFG_WRITE_FC:       r_wfc <= i_cfg_data[7:0];
                tspd_pkg::CFG_READ_FC:        r_rfc <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_power_divisor = (r_div == 32'd0) ? 32'd1 : r_div;
    assign o_ready = i_job_ready;
    assign take    = i_valid && i_job_ready;
    assign en      = (r_dev != 8'd0) && (r_dev <= tspd_pkg::MAX_VALID_ADDRESS);
    assign match   = en && (i_item.source_address == r_dev);

    // Sequencer state update and item classification.
    always_comb begin
        n_cd   = r_cd;
        n_mode = r_mode;
        n_miss = r_miss;
        n_job  = '0;
        n_job.speed_bits  = {i_item.result_word3, i_item.result_word2};
        n_job.torque_bits = {i_item.result_word1, i_item.result_word0};
        case (i_item.req_type)
            tspd_pkg::REQ_TICK: begin
                if (r_cd != 16'd0) n_cd = r_cd - 16'd1;
            end
            tspd_pkg::REQ_POLL: begin
                if (en && r_cd == 16'd0) begin
                    if (r_miss > r_max) n_mode = 1'b0;
                    if (i_item.bus_accepts) begin
                        n_job.send_request = n_mode ? tspd_pkg::SEND_READ
                                                    : tspd_pkg::SEND_START;
                        n_cd = r_resend;
                        if (r_miss != tspd_pkg::MISS_SATURATE) n_miss = r_miss + 8'd1;
                    end
                end
            end
            tspd_pkg::REQ_REPLY: begin
                if (match) begin
                    n_miss = 8'd0;
                    if (i_item.function_code == r_rfc) begin
                        n_job.decode = (i_item.byte_count == REPLY_BYTES);
                    end else if (i_item.function_code == r_wfc) begin
                        n_cd   = r_conv;
                        n_mode = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        n_job.link_lost = n_miss > r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd   <= 16'd0;
            r_mode <= 1'b0;
            r_miss <= 8'd0;
        end else if (take) begin
            r_cd   <= n_cd;
            r_mode <= n_mode;
            r_miss <= n_miss;
        end
    end

    assign o_job_valid = take;
    assign o_job       = n_job;

endmodule

`default_nettype wire

FILE: rtl/tspd_queue.sv
`default_nettype none

module tspd_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire tspd_pkg::t_job i_job,
    output logic                o_valid,
    input  wire                 i_ready,
    output tspd_pkg::t_job      o_job
);

    // Two-entry queue between classification and decode.
    tspd_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tspd_back.sv
`default_nettype none

module tspd_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire [31:0]            i_divisor,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire tspd_pkg::t_job   i_job,
    output logic                  o_valid,
    input  wire                   i_ready,
    output tspd_pkg::t_out_item   o_item
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL1  = 7'b0000010,
        ST_MUL2  = 7'b0000100,
        ST_MUL3  = 7'b0001000,
        ST_SHIFT = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state r_st;
    tspd_pkg::t_job r_job;
    logic [31:0] r_speed, r_torque, r_power;
    logic        r_ovalid;
    tspd_pkg::t_out_item r_out;
    logic [47:0] r_prod;
    logic [61:0] r_q;
    logic [63:0] r_num;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [6:0]  r_bit;
    logic [31:0] r_smilli, r_tmilli;
    logic        r_pzero, r_psat;
    logic [9:0]  r_e;

    // Field extraction of both floats.
    logic        s_neg, t_neg, s_nan, t_nan, s_inf, t_inf, s_zero, t_zero;
    logic [23:0] s_man, t_man;
    logic [8:0]  s_e, t_e;

    always_comb begin
        s_neg  = r_job.speed_bits[31];
        t_neg  = r_job.torque_bits[31];
        s_nan  = &r_job.speed_bits[30:23] && |r_job.speed_bits[22:0];
        t_nan  = &r_job.torque_bits[30:23] && |r_job.torque_bits[22:0];
        s_inf  = &r_job.speed_bits[30:23] && !(|r_job.speed_bits[22:0]);
        t_inf  = &r_job.torque_bits[30:23] && !(|r_job.torque_bits[22:0]);
        s_man  = {|r_job.speed_bits[30:23], r_job.speed_bits[22:0]};
        t_man  = {|r_job.torque_bits[30:23], r_job.torque_bits[22:0]};
        s_zero = s_man == 24'd0;
        t_zero = t_man == 24'd0;
        // biased exponent, subnormals behave as exponent one
        s_e = (r_job.speed_bits[30:23] == 8'd0) ? 9'd1 : {1'b0, r_job.speed_bits[30:23]};
        t_e = (r_job.torque_bits[30:23] == 8'd0) ? 9'd1 : {1'b0, r_job.torque_bits[30:23]};
    end

    // Float to milli conversion: mant*1000 * 2^(e-150), truncated, saturated.
    function automatic logic [31:0] to_milli(input logic [31:0] bits);
        logic [23:0] man;
        logic [7:0]  ef;
        logic [33:0] v;
        logic [31:0] lim;
        logic [63:0] mag;
        logic        neg;
        integer      sh;
        neg = bits[31];
        ef  = bits[30:23];
        man = {|ef, bits[22:0]};
        lim = neg ? 32'h80000000 : 32'h7FFFFFFF;
        v   = 34'(man) * 34'(tspd_pkg::MILLI_SCALE);
        sh  = (ef == 8'd0) ? -149 : (int'(ef) - 150);
        if (&ef && |bits[22:0]) begin
            mag = 64'd0;
        end else if (&ef) begin
            mag = 64'(lim);
        end else if (sh >= 0) begin
            if (sh >= 30) mag = (v == 34'd0) ? 64'd0 : 64'(lim);
            else          mag = 64'(v) << sh;
        end else begin
            mag = (-sh >= 34) ? 64'd0 : (64'(v) >> (-sh));
        end
        if (mag > 64'(lim)) mag = 64'(lim);
        to_milli = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    endfunction

    // Power exponent: both float exponents less a bias of 150 each, plus the 2^6 part of 10^6.
    logic signed [10:0] pe;
    assign pe = $signed({2'b0, s_e}) + $signed({2'b0, t_e}) - 11'sd294;

    // Scaling of the product by 2^r_e ahead of the divider.
    logic [9:0]  neg_e;
    logic        ovf;
    logic [63:0] num_in;

    assign neg_e = 10'd0 - r_e;

    always_comb begin
        ovf    = 1'b0;
        num_in = 64'd0;
        if (!r_e[9]) begin
            if (r_e >= 10'd64) begin
                ovf = 1'b1;
            end else begin
                ovf    = (64'(r_q) >> (7'd64 - 7'(r_e))) != 64'd0;
                num_in = 64'(r_q) << r_e[5:0];
            end
        end else begin
            num_in = (neg_e >= 10'd64) ? 64'd0 : (64'(r_q) >> neg_e[5:0]);
        end
    end

    assign o_ready = r_st == ST_IDLE;

    // Sequenced multiply, scale, then restoring division one bit a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_speed  <= 32'd0;
            r_torque <= 32'd0;
            r_power  <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_st != ST_OUT) r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_job <= i_job;
                        r_st  <= i_job.decode ? ST_MUL1 : ST_OUT;
                    end
                end
                ST_MUL1: begin
                    r_prod   <= 48'(s_man) * 48'(t_man);
                    r_smilli <= to_milli(r_job.speed_bits);
                    r_tmilli <= to_milli(r_job.torque_bits);
                    r_pzero  <= s_nan || t_nan || ((s_inf || t_inf) &&
                                ((!s_inf && s_zero) || (!t_inf && t_zero)))
                                || (s_neg != t_neg);
                    r_psat   <= s_inf || t_inf;
                    r_e      <= pe[9:0];
                    r_st     <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_q  <= 62'(r_prod[23:0]) * 62'(tspd_pkg::MEGA_ODD_PART);
                    r_st <= ST_MUL3;
                end
                ST_MUL3: begin
                    r_q  <= r_q + ((62'(r_prod[47:24]) * 62'(tspd_pkg::MEGA_ODD_PART)) << 24);
                    r_st <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    // Zero and saturated results skip the divider.
                    r_bit <= 7'd64;
                    r_rem <= 64'd0;
                    r_quo <= 64'd0;
                    if (r_pzero || r_q == 62'd0) begin
                        r_power <= 32'd0;
                        r_st    <= ST_OUT;
                    end else if (r_psat || ovf) begin
                        r_power <= 32'hFFFFFFFF;
                        r_st    <= ST_OUT;
                    end else begin
                        r_num <= num_in;
                        r_st  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_bit == 7'd0) begin
                        r_power <= (|r_quo[63:32]) ? 32'hFFFFFFFF : r_quo[31:0];
                        r_st    <= ST_OUT;
                    end else begin
                        if ({r_rem[62:0], r_num[63]} >= 64'(i_divisor)) begin
                            r_rem <= {r_rem[62:0], r_num[63]} - 64'(i_divisor);
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[62:0], r_num[63]};
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                        r_num <= {r_num[62:0], 1'b0};
                        r_bit <= r_bit - 7'd1;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        if (r_job.decode) begin
                            r_speed  <= r_smilli;
                            r_torque <= r_tmilli;
                        end
                        r_ovalid <= 1'b1;
                        r_st     <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // Output register; speed and torque take the new milli values on a decode, else hold r_speed/r_torque.
    always_ff @(posedge i_clk) begin
        if (r_st == ST_OUT && (!r_ovalid || i_ready)) begin
            r_out.send_request <= r_job.send_request;
            r_out.link_lost    <= r_job.link_lost;
            r_out.speed_milli  <= r_job.decode ? r_smilli : r_speed;
            r_out.torque_milli <= r_job.decode ? r_tmilli : r_torque;
            r_out.power_milli  <= r_power;
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

FILE: rtl/torque_sensor_poll_and_decode.sv
// Ticks, polls and non-decoding replies pass the queue and the back end's IDLE
// and OUT states; a decoding read reply also takes three multiply steps, scale, 64-step divider.
// Throughput: items are classified at one per cycle, while the two-entry queue
// has room; the back end retires one item at a time, bounded by the serial divider.
// Reset (i_rst_n low, synchronous) loads register defaults and clears state.
`default_nettype none

module torque_sensor_poll_and_decode #(
    parameter int RESULT_REG_COUNT = 5
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire [2:0]                i_cfg_index,
    input  wire [31:0]               i_cfg_data,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire tspd_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire                      i_ready,
    output tspd_pkg::t_out_item      o_item
);

    tspd_pkg::t_job fq_job, qb_job;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    logic [31:0] divisor;

    tspd_front #(.RESULT_REG_COUNT(RESULT_REG_COUNT)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .o_ready, .i_item,
        .o_job_valid(fq_valid), .i_job_ready(fq_ready), .o_job(fq_job),
        .o_power_divisor(divisor)
    );

    tspd_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(fq_valid), .o_ready(fq_ready), .i_job(fq_job),
        .o_valid(qb_valid), .i_ready(qb_ready), .o_job(qb_job)
    );

    tspd_back u_back (
        .i_clk, .i_rst_n, .i_divisor(divisor),
        .i_valid(qb_valid), .o_ready(qb_ready), .i_job(qb_job),
        .o_valid, .i_ready, .o_item
    );

endmodule

`default_nettype wire

FILE: rtl/tspd_checker.sv
`default_nettype none

module tspd_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      o_valid,
    input wire                      i_ready,
    input wire tspd_pkg::t_out_item o_item
);

    // A stalled result item holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result item changed while stalled");

    // Send code is never the unused value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.send_request != tspd_pkg::SEND_UNUSED)
        else $error("illegal send code");

    // No result is shown right after reset.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind torque_sensor_poll_and_decode tspd_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_item
);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

module testbench;

    localparam int REG_COUNT = 5;
    localparam int CYCLE_LIMIT = 2000000;

    // Predicted sensor behavior: configuration copy, poll state and the
    // queue of result items still to come from the block.
    class sensor_scoreboard;
        logic [7:0]  dev_addr;
        logic [7:0]  miss_limit;
        logic [15:0] conv_ticks;
        logic [15:0] resend_ticks;
        logic [31:0] divisor;
        logic [7:0]  write_code;
        logic [7:0]  read_code;
        logic [15:0] countdown;
        logic        reading;
        logic [7:0]  misses;
        logic [31:0] speed_val;
        logic [31:0] torque_val;
        logic [31:0] power_val;
        tspd_pkg::t_out_item pending[$];
        int          errors;
        int          checked;
        int          decodes;

        function new();
            errors = 0;
            checked = 0;
            decodes = 0;
            reset_state();
        endfunction

        function void reset_state();
            dev_addr = 8'd0;
            miss_limit = 8'd3;
            conv_ticks = 16'd100;
            resend_ticks = 16'd200;
            divisor = 32'd9549;
            write_code = 8'd6;
            read_code = 8'd4;
            countdown = '0;
            reading = 1'b0;
            misses = '0;
            speed_val = '0;
            torque_val = '0;
            power_val = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                tspd_pkg::CFG_DEVICE_ADDRESS: dev_addr = val[7:0];
                tspd_pkg::CFG_MAX_MISSES:     miss_limit = val[7:0];
                tspd_pkg::CFG_CONVERT_TICKS:  conv_ticks = val[15:0];
                tspd_pkg::CFG_RESEND_TICKS:   resend_ticks = val[15:0];
                tspd_pkg::CFG_POWER_DIVISOR:  divisor = val;
                tspd_pkg::CFG_WRITE_FC:       write_code = val[7:0];
                tspd_pkg::CFG_READ_FC:        read_code = val[7:0];
                default: ;
            endcase
        endfunction

        // Float bits to value times 1000, truncated and saturated.
        function logic [31:0] milli_of(logic [31:0] bits);
            logic [7:0]   ef;
            logic [63:0]  mant;
            logic [63:0]  lim;
            logic [127:0] v;
            int           ex;
            ef = bits[30:23];
            lim = bits[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (ef == 8'hFF && bits[22:0] != 0) return 32'd0;
            if (ef == 8'hFF) begin
                v = 128'(lim);
            end else begin
                mant = (ef == 0) ? {41'd0, bits[22:0]} : {40'd0, 1'b1, bits[22:0]};
                ex = (ef == 0) ? -149 : int'(ef) - 150;
                v = 128'(mant) * 128'd1000;
                if (ex >= 0) v = (ex >= 64) ? (v == 0 ? 128'd0 : {128{1'b1}}) : v << ex;
                else v = (-ex >= 128) ? 128'd0 : v >> (-ex);
                if (v > 128'(lim)) v = 128'(lim);
            end
            return bits[31] ? 32'd0 - v[31:0] : v[31:0];
        endfunction

        // Power from speed and torque bits: exact product scaled by 10^6, over the divisor.
        function logic [31:0] power_of(logic [31:0] sb, logic [31:0] tb);
            logic [63:0]  sm, tm;
            logic [255:0] q;
            int           e;
            logic         s_inf, t_inf, s_zero, t_zero, neg;
            if ((sb[30:23] == 8'hFF && sb[22:0] != 0) ||
                (tb[30:23] == 8'hFF && tb[22:0] != 0)) return 32'd0;
            neg = sb[31] ^ tb[31];
            s_inf = sb[30:23] == 8'hFF;
            t_inf = tb[30:23] == 8'hFF;
            s_zero = sb[30:0] == 0;
            t_zero = tb[30:0] == 0;
            if (s_inf || t_inf) begin
                if ((!s_inf && s_zero) || (!t_inf && t_zero)) return 32'd0;
                return neg ? 32'd0 : 32'hFFFF_FFFF;
            end
            if (s_zero || t_zero || neg) return 32'd0;
            sm = (sb[30:23] == 0) ? {41'd0, sb[22:0]} : {40'd0, 1'b1, sb[22:0]};
            tm = (tb[30:23] == 0) ? {41'd0, tb[22:0]} : {40'd0, 1'b1, tb[22:0]};
            e = ((sb[30:23] == 0) ? -149 : int'(sb[30:23]) - 150)
              + ((tb[30:23] == 0) ? -149 : int'(tb[30:23]) - 150) + 6;
            q = 256'(sm) * 256'(tm) * 256'd15625;
            if (e >= 0) begin
                if (e >= 64 || q > ({256'd0, 64'hFFFF_FFFF_FFFF_FFFF} >> e))
                    return 32'hFFFF_FFFF;
                q = q << e;
            end else begin
                q = q >> (-e);
            end
            q = q / ((divisor == 0) ? 256'd1 : {224'd0, divisor});
            return (q > 256'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        endfunction

        // Note one accepted input item and queue the result it causes.
        function void note_input(tspd_pkg::t_in_item it);
            logic [1:0]  send;
            logic        on;
            tspd_pkg::t_out_item r;
            send = tspd_pkg::SEND_NONE;
            on = dev_addr != 0 && dev_addr <= tspd_pkg::MAX_VALID_ADDRESS;
            case (it.req_type)
                tspd_pkg::REQ_TICK: if (countdown != 0) countdown = countdown - 16'd1;
                tspd_pkg::REQ_POLL: begin
                    if (on && countdown == 0) begin
                        if (misses > miss_limit) reading = 1'b0;
                        if (it.bus_accepts) begin
                            send = reading ? tspd_pkg::SEND_READ : tspd_pkg::SEND_START;
                            countdown = resend_ticks;
                            if (misses != tspd_pkg::MISS_SATURATE) misses = misses + 8'd1;
                        end
                    end
                end
                tspd_pkg::REQ_REPLY: begin
                    if (on && it.source_address == dev_addr) begin
                        misses = '0;
                        if (it.function_code == read_code) begin
                            if (it.byte_count == 2 * REG_COUNT) begin
                                speed_val = milli_of({it.result_word3, it.result_word2});
                                torque_val = milli_of({it.result_word1, it.result_word0});
                                power_val = power_of({it.result_word3, it.result_word2},
                                                     {it.result_word1, it.result_word0});
                                decodes++;
                            end
                        end else if (it.function_code == write_code) begin
                            countdown = conv_ticks;
                            reading = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            r.send_request = send;
            r.link_lost = misses > miss_limit;
            r.speed_milli = speed_val;
            r.torque_milli = torque_val;
            r.power_milli = power_val;
            pending.push_back(r);
        endfunction

        // Compare one result item with the oldest expectation.
        function void check_result(tspd_pkg::t_out_item got);
            tspd_pkg::t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.send_request !== want.send_request) begin
                $display("%0t: send_request expected %0d actual %0d", $time,
                         want.send_request, got.send_request);
                errors++;
            end
            if (got.link_lost !== want.link_lost) begin
                $display("%0t: link_lost expected %0d actual %0d", $time,
                         want.link_lost, got.link_lost);
                errors++;
            end
            if (got.speed_milli !== want.speed_milli) begin
                $display("%0t: speed_milli expected %0d actual %0d", $time,
                         want.speed_milli, got.speed_milli);
                errors++;
            end
            if (got.torque_milli !== want.torque_milli) begin
                $display("%0t: torque_milli expected %0d actual %0d", $time,
                         want.torque_milli, got.torque_milli);
                errors++;
            end
            if (got.power_milli !== want.power_milli) begin
                $display("%0t: power_milli expected %0d actual %0d", $time,
                         want.power_milli, got.power_milli);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    tspd_pkg::t_in_item  in_item;
    logic        out_valid;
    logic        out_ready;
    tspd_pkg::t_out_item out_item;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;
    int cycles;
    sensor_scoreboard sb;

    torque_sensor_poll_and_decode #(.RESULT_REG_COUNT(REG_COUNT)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_item(in_item),
        .o_valid(out_valid), .i_ready(out_ready), .o_item(out_item)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle counter and timeout.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_item);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Wait until every expected result has come back.
    task automatic wait_empty();
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Configuration is written only once the block holds no item.
    task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
        in_valid <= 1'b0;
        wait_empty();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Offer one item after a random gap and wait until it is accepted.
    task automatic send_item(tspd_pkg::t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait_empty();
        repeat (100) @(posedge clk);
    endtask

    function automatic tspd_pkg::t_in_item make_item(logic [1:0] kind, logic acc,
                                                     logic [7:0] src, logic [7:0] fc,
                                                     logic [7:0] len, logic [31:0] tq,
                                                     logic [31:0] sp);
        tspd_pkg::t_in_item it;
        it.req_type = kind;
        it.bus_accepts = acc;
        it.source_address = src;
        it.function_code = fc;
        it.byte_count = len;
        it.result_word0 = tq[15:0];
        it.result_word1 = tq[31:16];
        it.result_word2 = sp[15:0];
        it.result_word3 = sp[31:16];
        return it;
    endfunction

    function automatic tspd_pkg::t_in_item tick_item();
        return make_item(tspd_pkg::REQ_TICK, 1'b0, 8'd0, 8'd0, 8'd0, 32'd0, 32'd0);
    endfunction

    function automatic tspd_pkg::t_in_item poll_item(logic acc);
        return make_item(tspd_pkg::REQ_POLL, acc, 8'd0, 8'd0, 8'd0, 32'd0, 32'd0);
    endfunction

    function automatic tspd_pkg::t_in_item reply_item(logic [7:0] src, logic [7:0] fc,
                                                      logic [7:0] len, logic [31:0] tq,
                                                      logic [31:0] sp);
        return make_item(tspd_pkg::REQ_REPLY, 1'b0, src, fc, len, tq, sp);
    endfunction

    // Random float bits leaning toward values in a useful range.
    function automatic logic [31:0] rand_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(9))
            0: f[30:23] = 8'hFF;
            1: f[30:23] = 8'h00;
            2: f[30:0] = '0;
            default: f[30:23] = 8'($urandom_range(110, 160));
        endcase
        return f;
    endfunction

    // Random item, mostly a well-formed poll cycle element with random content.
    function automatic tspd_pkg::t_in_item rand_item();
        logic [7:0] src, fc, len;
        int pick;
        pick = $urandom_range(99);
        src = ($urandom_range(9) == 0) ? 8'($urandom) : sb.dev_addr;
        len = ($urandom_range(7) == 0) ? 8'($urandom) : 8'(2 * REG_COUNT);
        fc = ($urandom_range(1)) ? sb.read_code : sb.write_code;
        if ($urandom_range(9) == 0) fc = 8'($urandom);
        if (pick < 35)
            return make_item(tspd_pkg::REQ_TICK, 1'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), $urandom, $urandom);
        if (pick < 65)
            return make_item(tspd_pkg::REQ_POLL, $urandom_range(3) != 0, 8'($urandom),
                             8'($urandom), 8'($urandom), $urandom, $urandom);
        if (pick < 97)
            return make_item(tspd_pkg::REQ_REPLY, 1'($urandom), src, fc, len,
                             rand_float(), rand_float());
        return make_item(tspd_pkg::REQ_NONE, 1'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), $urandom, $urandom);
    endfunction

    task automatic random_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_item(rand_item());
        drain();
    endtask

    initial begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: disabled block, then short countdowns at address 1.
        send_item(poll_item(1'b1));
        send_item(reply_item(8'd0, 8'd4, 8'd10, 32'h3F80_0000, 32'h4000_0000));
        write_cfg(tspd_pkg::CFG_DEVICE_ADDRESS, 32'd1);
        write_cfg(tspd_pkg::CFG_CONVERT_TICKS, 32'd1);
        write_cfg(tspd_pkg::CFG_RESEND_TICKS, 32'd2);
        write_cfg(tspd_pkg::CFG_MAX_MISSES, 32'd1);
        send_item(poll_item(1'b0));
        send_item(poll_item(1'b1));
        send_item(poll_item(1'b1));
        send_item(tick_item());
        send_item(tick_item());
        send_item(tick_item());
        send_item(reply_item(8'd1, 8'd6, 8'd0, 32'd0, 32'd0));
        send_item(tick_item());
        send_item(poll_item(1'b1));
        send_item(reply_item(8'd2, 8'd4, 8'd10, 32'h3F80_0000, 32'h4000_0000));
        send_item(reply_item(8'd1, 8'd4, 8'd9, 32'h3F80_0000, 32'h4000_0000));
        send_item(reply_item(8'd1, 8'd4, 8'd10, 32'h4120_0000, 32'h44FA_0000));
        send_item(reply_item(8'd1, 8'd4, 8'd10, 32'hC120_0000, 32'h44FA_0000));
        send_item(reply_item(8'd1, 8'd4, 8'd10, 32'h7FC0_0000, 32'h7F80_0000));
        send_item(reply_item(8'd1, 8'd4, 8'd10, 32'h0000_0000, 32'hFF80_0000));
        send_item(reply_item(8'd1, 8'd4, 8'd10, 32'h7F7F_FFFF, 32'h0000_0001));
        send_item(reply_item(8'd1, 8'd4, 8'd10, 32'h7F7F_FFFF, 32'h7F7F_FFFF));
        send_item(reply_item(8'd1, 8'd4, 8'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(tspd_pkg::REQ_NONE, 1'b1, 8'hFF, 8'hFF, 8'hFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drain();

        // Equal codes, extreme divisors and counts, high address.
        write_cfg(tspd_pkg::CFG_WRITE_FC, 32'd4);
        write_cfg(tspd_pkg::CFG_POWER_DIVISOR, 32'd1);
        send_item(reply_item(8'd1, 8'd4, 8'd10, 32'h4120_0000, 32'h4120_0000));
        write_cfg(tspd_pkg::CFG_DEVICE_ADDRESS, 32'd248);
        send_item(poll_item(1'b1));
        drain();
        write_cfg(tspd_pkg::CFG_DEVICE_ADDRESS, 32'd247);
        write_cfg(tspd_pkg::CFG_WRITE_FC, 32'd255);
        write_cfg(tspd_pkg::CFG_READ_FC, 32'd0);
        write_cfg(tspd_pkg::CFG_MAX_MISSES, 32'd0);
        write_cfg(tspd_pkg::CFG_CONVERT_TICKS, 32'd0);
        write_cfg(tspd_pkg::CFG_RESEND_TICKS, 32'd0);
        write_cfg(tspd_pkg::CFG_POWER_DIVISOR, 32'hFFFF_FFFF);
        random_phase(200, 0, 0);

        // Long receiver hold-off while the sender keeps offering items.
        hold_off = 400;
        random_phase(30, 0, 0);

        write_cfg(tspd_pkg::CFG_DEVICE_ADDRESS, 32'd5);
        write_cfg(tspd_pkg::CFG_MAX_MISSES, 32'd254);
        write_cfg(tspd_pkg::CFG_CONVERT_TICKS, 32'd3);
        write_cfg(tspd_pkg::CFG_RESEND_TICKS, 32'd5);
        write_cfg(tspd_pkg::CFG_POWER_DIVISOR, 32'd9549);
        write_cfg(tspd_pkg::CFG_WRITE_FC, 32'd6);
        write_cfg(tspd_pkg::CFG_READ_FC, 32'd4);
        random_phase(190, 65, 0);
        write_cfg(tspd_pkg::CFG_CONVERT_TICKS, 32'd65535);
        write_cfg(tspd_pkg::CFG_RESEND_TICKS, 32'd65535);
        write_cfg(tspd_pkg::CFG_MAX_MISSES, 32'd2);
        random_phase(190, 0, 65);
        write_cfg(tspd_pkg::CFG_RESEND_TICKS, 32'd1);
        write_cfg(tspd_pkg::CFG_CONVERT_TICKS, 32'd2);
        write_cfg(tspd_pkg::CFG_POWER_DIVISOR, 32'd1000000);
        random_phase(190, 27, 27);

        $display("Covered %0d result items, %0d decoded read replies, over six settings.",
                 sb.checked, sb.decodes);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/tspd_pkg.sv
rtl/tspd_front.sv
rtl/tspd_queue.sv
rtl/tspd_back.sv
rtl/torque_sensor_poll_and_decode.sv
rtl/tspd_checker.sv
tb/testbench.sv
